// ----- rtl/core/gfq_pkg.sv -----
// Package for the grouped FIFO queue: shared types, codes and field widths.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package gfq_pkg;

  // Field widths of the stream payloads
  localparam int unsigned ID_W       = 20;
  localparam int unsigned GRP_W      = 10;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned STAT_W     = 2;

  // Operation kind carried in the input tuser
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_ENQ   = 2'd0,
    STAT_DEQ   = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD_HI,
    ST_MOD_LO,
    ST_ENQ_RD,
    ST_ENQ_WR,
    ST_DEQ_RD,
    ST_DEQ_SLOT,
    ST_DEQ_WR,
    ST_RESP
  } state_e;

  // Commands from controller to datapath
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_ACCEPT,
    CMD_MOD_HI,
    CMD_MOD_LO,
    CMD_ENQ_RD,
    CMD_ENQ_WR,
    CMD_DEQ_RD,
    CMD_DEQ_SLOT,
    CMD_DEQ_WR,
    CMD_FULL,
    CMD_EMPTY,
    CMD_PUSH
  } cmd_e;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_done;  // last entry of the group-flag clearing pass
    logic in_deq;    // incoming item is a dequeue
    logic full;      // all entry slots occupied
    logic active;    // active-group list not empty
    logic out_free;  // output register can take a result this cycle
  } dp_status_t;

endpackage

// ----- rtl/core/gfq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used by the grouped FIFO queue datapath; no dependencies.
`timescale 1ns / 1ps

module gfq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/gfq_ctrl.sv -----
// Controller state machine of the grouped FIFO queue.
// Sequences clearing, enqueue and dequeue steps; uses gfq_pkg types.
`timescale 1ns / 1ps

module gfq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  gfq_pkg::dp_status_t status_i,
  output gfq_pkg::cmd_e       cmd_o
);

  gfq_pkg::state_e state_q, state_d;

  // State register; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gfq_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gfq_pkg::ST_CLEAR: begin
        if (status_i.clr_done) state_d = gfq_pkg::ST_IDLE;
      end
      gfq_pkg::ST_IDLE: begin
        if (s_tvalid_i) begin
          state_d = status_i.in_deq ? gfq_pkg::ST_DEQ_RD : gfq_pkg::ST_MOD_HI;
        end
      end
      gfq_pkg::ST_MOD_HI:   state_d = gfq_pkg::ST_MOD_LO;
      gfq_pkg::ST_MOD_LO:   state_d = gfq_pkg::ST_ENQ_RD;
      gfq_pkg::ST_ENQ_RD: begin
        state_d = status_i.full ? gfq_pkg::ST_RESP : gfq_pkg::ST_ENQ_WR;
      end
      gfq_pkg::ST_ENQ_WR:   state_d = gfq_pkg::ST_RESP;
      gfq_pkg::ST_DEQ_RD: begin
        state_d = status_i.active ? gfq_pkg::ST_DEQ_SLOT : gfq_pkg::ST_RESP;
      end
      gfq_pkg::ST_DEQ_SLOT: state_d = gfq_pkg::ST_DEQ_WR;
      gfq_pkg::ST_DEQ_WR:   state_d = gfq_pkg::ST_RESP;
      gfq_pkg::ST_RESP: begin
        if (status_i.out_free) state_d = gfq_pkg::ST_IDLE;
      end
      default: state_d = gfq_pkg::ST_CLEAR;
    endcase
  end

  // Outputs: ready and datapath command
  always_comb begin
    s_tready_o = 1'b0;
    cmd_o      = gfq_pkg::CMD_NONE;
    case (state_q)
      gfq_pkg::ST_CLEAR: cmd_o = gfq_pkg::CMD_CLEAR;
      gfq_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) cmd_o = gfq_pkg::CMD_ACCEPT;
      end
      gfq_pkg::ST_MOD_HI: cmd_o = gfq_pkg::CMD_MOD_HI;
      gfq_pkg::ST_MOD_LO: cmd_o = gfq_pkg::CMD_MOD_LO;
      gfq_pkg::ST_ENQ_RD: begin
        cmd_o = status_i.full ? gfq_pkg::CMD_FULL : gfq_pkg::CMD_ENQ_RD;
      end
      gfq_pkg::ST_ENQ_WR: cmd_o = gfq_pkg::CMD_ENQ_WR;
      gfq_pkg::ST_DEQ_RD: begin
        cmd_o = status_i.active ? gfq_pkg::CMD_DEQ_RD : gfq_pkg::CMD_EMPTY;
      end
      gfq_pkg::ST_DEQ_SLOT: cmd_o = gfq_pkg::CMD_DEQ_SLOT;
      gfq_pkg::ST_DEQ_WR:   cmd_o = gfq_pkg::CMD_DEQ_WR;
      gfq_pkg::ST_RESP: begin
        if (status_i.out_free) cmd_o = gfq_pkg::CMD_PUSH;
      end
      default: cmd_o = gfq_pkg::CMD_NONE;
    endcase
  end

endmodule

// ----- rtl/core/gfq_dp.sv -----
// Datapath of the grouped FIFO queue: entry and group memories, list pointers,
// group index reduction and the output register. Uses gfq_pkg and gfq_ram.
`timescale 1ns / 1ps

module gfq_dp #(
  parameter int unsigned GROUPS   = 1024,
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gfq_pkg::cmd_e                     cmd_i,
  output gfq_pkg::dp_status_t               status_o,
  input  logic [gfq_pkg::IN_DATA_W-1:0]     s_tdata_i,
  input  logic                              s_tuser_i,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [gfq_pkg::OUT_DATA_W-1:0]    m_tdata_o,
  output logic [gfq_pkg::STAT_W-1:0]        m_tuser_o
);

  localparam int unsigned GIW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned CIW = $clog2(CAPACITY);
  localparam int unsigned ID_W  = gfq_pkg::ID_W;
  localparam int unsigned GRP_W = gfq_pkg::GRP_W;

  // Group index reduction by reciprocal multiplication: the scaled quotient
  // estimate is low by at most one, fixed by one compare and subtract
  localparam int unsigned RS = GRP_W + GIW;
  localparam int unsigned PW = GRP_W + RS + 1;
  localparam int unsigned RW = GRP_W + GIW;
  localparam logic [RS:0] RECIP = (RS+1)'((64'd1 << RS) / GROUPS);

  // Control registers
  logic [CIW-1:0] free_head_q, free_head_d;
  logic [CIW:0]   hw_q, hw_d;      // slots below this mark have been handed out once
  logic [CIW:0]   used_q, used_d;
  logic [GIW-1:0] head_q, head_d;
  logic [GIW-1:0] tail_q, tail_d;
  logic           active_q, active_d;
  logic [GIW-1:0] clr_q, clr_d;
  logic           out_valid_q, out_valid_d;

  // Payload registers
  logic [ID_W-1:0]        id_q;
  logic [GRP_W-1:0]       grp_q;
  logic [GRP_W-1:0]       quo_q;
  logic [GIW-1:0]         g_q;
  logic [CIW-1:0]         slot_q;
  logic                   last_hit_q;
  logic [GIW-1:0]         succ_q;
  gfq_pkg::status_e       res_status_q;
  logic [ID_W-1:0]        res_id_q;
  gfq_pkg::status_e       out_status_q;
  logic [ID_W-1:0]        out_id_q;

  logic [PW-1:0]  recip_prod;
  logic [RW-1:0]  rem_raw, rem_fix;
  logic           out_free;

  // Memory ports
  logic            ids_we;
  logic [CIW-1:0]  ids_waddr, ids_raddr;
  logic [ID_W-1:0] ids_wdata, ids_rd;
  logic            link_we;
  logic [CIW-1:0]  link_waddr, link_raddr, link_wdata, link_rd;
  logic            first_we;
  logic [GIW-1:0]  first_waddr, first_raddr;
  logic [CIW-1:0]  first_wdata, first_rd;
  logic            last_we;
  logic [GIW-1:0]  last_waddr, last_raddr;
  logic [CIW-1:0]  last_wdata, last_rd;
  logic            ne_we;
  logic [GIW-1:0]  ne_waddr, ne_raddr;
  logic            ne_wdata, ne_rd;
  logic            succ_we;
  logic [GIW-1:0]  succ_waddr, succ_raddr, succ_wdata, succ_rd;

  gfq_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_ids (
    .clk_i, .we_i(ids_we), .waddr_i(ids_waddr), .wdata_i(ids_wdata),
    .raddr_i(ids_raddr), .rdata_o(ids_rd)
  );
  gfq_ram #(.WIDTH(CIW), .DEPTH(CAPACITY)) u_links (
    .clk_i, .we_i(link_we), .waddr_i(link_waddr), .wdata_i(link_wdata),
    .raddr_i(link_raddr), .rdata_o(link_rd)
  );
  gfq_ram #(.WIDTH(CIW), .DEPTH(GROUPS)) u_first (
    .clk_i, .we_i(first_we), .waddr_i(first_waddr), .wdata_i(first_wdata),
    .raddr_i(first_raddr), .rdata_o(first_rd)
  );
  gfq_ram #(.WIDTH(CIW), .DEPTH(GROUPS)) u_last (
    .clk_i, .we_i(last_we), .waddr_i(last_waddr), .wdata_i(last_wdata),
    .raddr_i(last_raddr), .rdata_o(last_rd)
  );
  gfq_ram #(.WIDTH(1), .DEPTH(GROUPS)) u_nonempty (
    .clk_i, .we_i(ne_we), .waddr_i(ne_waddr), .wdata_i(ne_wdata),
    .raddr_i(ne_raddr), .rdata_o(ne_rd)
  );
  gfq_ram #(.WIDTH(GIW), .DEPTH(GROUPS)) u_succ (
    .clk_i, .we_i(succ_we), .waddr_i(succ_waddr), .wdata_i(succ_wdata),
    .raddr_i(succ_raddr), .rdata_o(succ_rd)
  );

  // Group index reduction: quotient estimate first, then remainder and fix-up
  assign recip_prod = PW'(grp_q) * PW'(RECIP);
  assign rem_raw    = RW'(grp_q) - RW'(quo_q) * RW'(GROUPS);
  assign rem_fix    = (rem_raw >= RW'(GROUPS)) ? rem_raw - RW'(GROUPS) : rem_raw;

  // Memory addressing per command
  always_comb begin
    ids_we = 1'b0;  ids_waddr = '0;  ids_wdata = id_q;  ids_raddr = '0;
    link_we = 1'b0; link_waddr = '0; link_wdata = free_head_q; link_raddr = '0;
    first_we = 1'b0; first_waddr = '0; first_wdata = free_head_q; first_raddr = '0;
    last_we = 1'b0; last_waddr = '0; last_wdata = free_head_q; last_raddr = '0;
    ne_we = 1'b0;   ne_waddr = '0;   ne_wdata = 1'b0;  ne_raddr = '0;
    succ_we = 1'b0; succ_waddr = '0; succ_wdata = g_q; succ_raddr = '0;
    case (cmd_i)
      gfq_pkg::CMD_CLEAR: begin
        ne_we    = 1'b1;
        ne_waddr = clr_q;
      end
      gfq_pkg::CMD_ENQ_RD: begin
        link_raddr = free_head_q;
        ne_raddr   = g_q;
        last_raddr = g_q;
      end
      gfq_pkg::CMD_ENQ_WR: begin
        ids_we      = 1'b1;
        ids_waddr   = free_head_q;
        // append behind the group's old last slot
        link_we     = ne_rd;
        link_waddr  = last_rd;
        last_we     = 1'b1;
        last_waddr  = g_q;
        first_we    = !ne_rd;
        first_waddr = g_q;
        ne_we       = 1'b1;
        ne_waddr    = g_q;
        ne_wdata    = 1'b1;
        // newly active group goes behind the tail group
        succ_we     = !ne_rd && active_q;
        succ_waddr  = tail_q;
      end
      gfq_pkg::CMD_DEQ_RD: begin
        first_raddr = head_q;
        last_raddr  = head_q;
        succ_raddr  = head_q;
      end
      gfq_pkg::CMD_DEQ_SLOT: begin
        ids_raddr  = first_rd;
        link_raddr = first_rd;
      end
      gfq_pkg::CMD_DEQ_WR: begin
        // freed slot goes on top of the free chain
        link_we     = 1'b1;
        link_waddr  = slot_q;
        ne_we       = last_hit_q;
        ne_waddr    = head_q;
        first_we    = !last_hit_q;
        first_waddr = head_q;
        first_wdata = link_rd;
      end
      default: ;
    endcase
  end

  // Next values of list pointers and counters
  always_comb begin
    free_head_d = free_head_q;
    hw_d        = hw_q;
    used_d      = used_q;
    head_d      = head_q;
    tail_d      = tail_q;
    active_d    = active_q;
    clr_d       = clr_q;
    case (cmd_i)
      gfq_pkg::CMD_CLEAR: clr_d = clr_q + 1'b1;
      gfq_pkg::CMD_ENQ_WR: begin
        // untouched slots chain to the next index, the last one to slot zero
        if ({1'b0, free_head_q} == hw_q) begin
          hw_d = hw_q + 1'b1;
          if (hw_q == (CIW+1)'(CAPACITY - 1)) begin
            free_head_d = '0;
          end else begin
            free_head_d = hw_q[CIW-1:0] + 1'b1;
          end
        end else begin
          free_head_d = link_rd;
        end
        used_d = used_q + 1'b1;
        if (!ne_rd) begin
          tail_d = g_q;
          if (!active_q) begin
            head_d   = g_q;
            active_d = 1'b1;
          end
        end
      end
      gfq_pkg::CMD_DEQ_WR: begin
        if (last_hit_q) begin
          if (head_q == tail_q) begin
            active_d = 1'b0;
          end else begin
            head_d = succ_q;
          end
        end
        free_head_d = slot_q;
        if (used_q != '0) used_d = used_q - 1'b1;
      end
      default: ;
    endcase
  end

  // Output register handshake
  assign out_free = !out_valid_q || m_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i == gfq_pkg::CMD_PUSH) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      hw_q        <= '0;
      used_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      active_q    <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      free_head_q <= free_head_d;
      hw_q        <= hw_d;
      used_q      <= used_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      active_q    <= active_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      gfq_pkg::CMD_ACCEPT: begin
        id_q  <= s_tdata_i[ID_W-1:0];
        grp_q <= s_tdata_i[ID_W+GRP_W-1:ID_W];
      end
      gfq_pkg::CMD_MOD_HI: quo_q <= recip_prod[RS +: GRP_W];
      gfq_pkg::CMD_MOD_LO: g_q   <= rem_fix[GIW-1:0];
      gfq_pkg::CMD_FULL: begin
        res_status_q <= gfq_pkg::STAT_FULL;
        res_id_q     <= '0;
      end
      gfq_pkg::CMD_EMPTY: begin
        res_status_q <= gfq_pkg::STAT_EMPTY;
        res_id_q     <= '0;
      end
      gfq_pkg::CMD_ENQ_WR: begin
        res_status_q <= gfq_pkg::STAT_ENQ;
        res_id_q     <= '0;
      end
      gfq_pkg::CMD_DEQ_SLOT: begin
        slot_q     <= first_rd;
        last_hit_q <= (first_rd == last_rd);
        succ_q     <= succ_rd;
      end
      gfq_pkg::CMD_DEQ_WR: begin
        res_status_q <= gfq_pkg::STAT_DEQ;
        res_id_q     <= ids_rd;
      end
      gfq_pkg::CMD_PUSH: begin
        out_status_q <= res_status_q;
        out_id_q     <= res_id_q;
      end
      default: ;
    endcase
  end

  // Status to controller
  assign status_o.clr_done = (clr_q == GIW'(GROUPS - 1));
  assign status_o.in_deq   = (s_tuser_i == gfq_pkg::KIND_DEQ);
  assign status_o.full     = (used_q == (CIW+1)'(CAPACITY));
  assign status_o.active   = active_q;
  assign status_o.out_free = out_free;

  // Output stream
  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_status_q;
  assign m_tdata_o  = {{(gfq_pkg::OUT_DATA_W - ID_W){1'b0}}, out_id_q};

endmodule

// ----- rtl/core/grouped_fifo_queue_unit.sv -----
// Grouped FIFO queue (team queue) over shared linked entry storage.
// An enqueue runs group reduction, a memory read and a write; a dequeue a read, a slot
// read and a write; a dropped enqueue or a dequeue on an empty queue ends early without a write. One
// item at a time, paced by the dependent memory read-then-write steps and the output handshake.
// After reset the unit clears the group flag of every group with input ready low.
// Reset is asynchronous, active low; depends on gfq_pkg, gfq_ctrl and gfq_dp.
`timescale 1ns / 1ps

module grouped_fifo_queue_unit #(
  parameter int unsigned GROUPS   = 1024,
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [gfq_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,   // member_id[19:0], group_index[29:20]
  input  logic                           s_axis_tuser_i,   // kind
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [gfq_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,   // out_id[19:0]
  output logic [gfq_pkg::STAT_W-1:0]     m_axis_tuser_o    // status[1:0]
);

  gfq_pkg::cmd_e       cmd;
  gfq_pkg::dp_status_t dp_status;

  gfq_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  gfq_dp #(
    .GROUPS   (GROUPS),
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i      (cmd),
    .status_o   (dp_status),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

  // Only one item in flight: no new transfer right after one is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input ready right after an input transfer");

  // A pushed result shows up on the output
  a_push_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == gfq_pkg::CMD_PUSH) |=> m_axis_tvalid_o)
    else $error("result pushed but output not valid");

  // Only a successful dequeue carries an identifier
  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != gfq_pkg::STAT_DEQ)) |-> (m_axis_tdata_o == '0))
    else $error("nonzero identifier on a non-dequeue result");

endmodule
